// File: hdl/pfa_pkg.sv
// Shared types and constants for the partition fit allocator.
package pfa_pkg;

    localparam int NUM_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;
    localparam int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

    localparam int OPCODE_W   = 2;
    localparam int INDEX_W    = 4;
    localparam int AMOUNT_W   = 16;
    localparam int STATUS_W   = 2;
    localparam int CHOSEN_W   = 4;
    localparam int LEFT_W     = 16;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    localparam int STRAT_W    = 2;
    localparam int BCOUNT_W   = 5;
    localparam int CFG_DATA_W = 5;

    localparam logic CFG_STRATEGY    = 1'b0;
    localparam logic CFG_BLOCK_COUNT = 1'b1;

    localparam logic [STRAT_W-1:0] STRAT_BEST  = 2'd1;
    localparam logic [STRAT_W-1:0] STRAT_WORST = 2'd2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_RESTART = 2'd1,
        OP_ALLOC   = 2'd2,
        OP_NONE    = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOCATED = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_LOADED    = 2'd2,
        ST_RESTARTED = 2'd3
    } t_status;

    typedef struct packed {
        logic    accept;
        logic    load_wr;
        logic    copy;
        logic    scan;
        logic    alloc_wr;
        logic    out_ld;
        t_status out_status;
    } t_dp_cmd;

    typedef struct packed {
        logic copy_last;
        logic scan_end;
        logic found;
        logic first_fit;
    } t_dp_stat;

endpackage

// File: hdl/pfa_ctrl.sv
// Sequencing state machine and output valid for the partition fit allocator.
module pfa_ctrl
    import pfa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic [OPCODE_W-1:0] i_s_tuser,
    output logic                o_s_tready,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    input  t_dp_stat            i_stat,
    output t_dp_cmd             o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LOAD  = 6'b000010,
        S_COPY  = 6'b000100,
        S_SCAN  = 6'b001000,
        S_WRITE = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state  r_state, n_state;
    t_status r_res_status, n_res_status;
    logic    r_out_valid, n_out_valid;

    always_comb begin
        o_cmd        = '0;
        n_state      = r_state;
        n_res_status = r_res_status;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    unique case (t_opcode'(i_s_tuser))
                        OP_LOAD:    n_state = S_LOAD;
                        OP_RESTART: n_state = S_COPY;
                        OP_ALLOC:   n_state = S_SCAN;
                        OP_NONE: begin
                            n_res_status = ST_NO_FIT;
                            n_state      = S_DONE;
                        end
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_LOAD: begin
                o_cmd.load_wr = 1'b1;
                n_res_status  = ST_LOADED;
                n_state       = S_DONE;
            end
            S_COPY: begin
                o_cmd.copy = 1'b1;
                if (i_stat.copy_last) begin
                    n_res_status = ST_RESTARTED;
                    n_state      = S_DONE;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_end || (i_stat.found && i_stat.first_fit)) begin
                    if (i_stat.found) begin
                        n_state = S_WRITE;
                    end else begin
                        n_res_status = ST_NO_FIT;
                        n_state      = S_DONE;
                    end
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_WRITE: begin
                o_cmd.alloc_wr = 1'b1;
                n_res_status   = ST_ALLOCATED;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        o_cmd.out_status = r_res_status;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_ld) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_res_status <= ST_NO_FIT;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_res_status <= n_res_status;
            r_out_valid  <= n_out_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

`ifndef NO_ASSERTIONS
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_tready |=> r_out_valid)
        else $error("pending result dropped");

    a_write_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> $past(r_state == S_SCAN))
        else $error("allocation write without scan");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_ld |-> (!r_out_valid || i_m_tready))
        else $error("result register overwritten");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> (r_state != S_IDLE))
        else $error("accepted item not started");
`endif

endmodule

// File: hdl/pfa_datapath.sv
// Block table, scan unit, configuration registers and result register.
module pfa_datapath
    import pfa_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic                   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  t_dp_cmd                i_cmd,
    output t_dp_stat               o_stat,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic [STATUS_W-1:0]    o_m_tuser
);

    logic [STRAT_W-1:0]   r_strategy;
    logic [BCOUNT_W-1:0]  r_block_count;
    logic [SIZE_BITS-1:0] r_size [NUM_BLOCKS];
    logic [SIZE_BITS-1:0] r_rem  [NUM_BLOCKS];
    logic [INDEX_W-1:0]   r_idx;
    logic [SIZE_BITS-1:0] r_amt;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_found;
    logic [IDX_W-1:0]     r_pick;
    logic [SIZE_BITS-1:0] r_best;
    logic [STATUS_W-1:0]  r_out_status;
    logic [CHOSEN_W-1:0]  r_out_chosen;
    logic [LEFT_W-1:0]    r_out_left;

    logic [IDX_W-1:0]     w_ptr;
    logic [SIZE_BITS-1:0] w_rem;
    logic [SIZE_BITS-1:0] w_left;
    logic                 w_elig;
    logic                 w_take;
    logic                 w_first_fit;

    assign w_ptr       = r_cnt[IDX_W-1:0];
    assign w_rem       = r_rem[w_ptr];
    assign w_left      = w_rem - r_amt;
    assign w_elig      = (w_rem != '0) && (w_rem >= r_amt);
    assign w_first_fit = (r_strategy != STRAT_BEST) && (r_strategy != STRAT_WORST);
    assign w_take      = w_elig && (!r_found
                       || ((r_strategy == STRAT_BEST) && (w_left < r_best))
                       || ((r_strategy == STRAT_WORST) && (w_left > r_best)));

    assign o_stat.copy_last = (32'(r_cnt) == NUM_BLOCKS - 1);
    assign o_stat.scan_end  = (32'(r_cnt) >= 32'(r_block_count))
                           || (32'(r_cnt) >= NUM_BLOCKS);
    assign o_stat.found     = r_found;
    assign o_stat.first_fit = w_first_fit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strategy    <= '0;
            r_block_count <= '0;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == CFG_STRATEGY) begin
                r_strategy <= i_cfg_data[STRAT_W-1:0];
            end else begin
                r_block_count <= i_cfg_data[BCOUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_BLOCKS; k++) begin
                r_size[k] <= '0;
                r_rem[k]  <= '0;
            end
        end else if (i_cmd.load_wr) begin
            if (32'(r_idx) < NUM_BLOCKS) begin
                r_size[IDX_W'(r_idx)] <= r_amt;
                r_rem[IDX_W'(r_idx)]  <= r_amt;
            end
        end else if (i_cmd.copy) begin
            r_rem[w_ptr] <= r_size[w_ptr];
        end else if (i_cmd.alloc_wr) begin
            r_rem[r_pick] <= r_best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.accept) begin
            r_cnt   <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.copy || i_cmd.scan) begin
            r_cnt <= r_cnt + 1'b1;
            if (i_cmd.scan && w_take) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx <= i_s_tdata[INDEX_W-1:0];
            r_amt <= SIZE_BITS'(i_s_tdata[INDEX_W +: AMOUNT_W]);
        end
        if (i_cmd.scan && w_take) begin
            r_pick <= w_ptr;
            r_best <= w_left;
        end
        if (i_cmd.out_ld) begin
            r_out_status <= i_cmd.out_status;
            if (i_cmd.out_status == ST_ALLOCATED) begin
                r_out_chosen <= CHOSEN_W'(r_pick);
                r_out_left   <= LEFT_W'(r_best);
            end else begin
                r_out_chosen <= '0;
                r_out_left   <= '0;
            end
        end
    end

    assign o_m_tdata = {(OUT_TDATA_W - LEFT_W - CHOSEN_W)'(0), r_out_left, r_out_chosen};
    assign o_m_tuser = r_out_status;

endmodule

// File: hdl/partition_fit_allocator_unit.sv
// Top level of the partition fit allocator: controller plus datapath.
//
// Keeps a table of NUM_BLOCKS memory blocks (size, remaining capacity) and
// places requests by first, best or worst fit. Items arrive on s_axis_*
// (opcode in tuser; block index and amount in tdata), one result per item
// leaves on m_axis_* (status in tuser; chosen block and leftover in tdata).
// Strategy and block count are set through i_cfg_* while the block is idle;
// the user must keep to this, as the block itself does not enforce it. From
// accept to result in the output register: load writes the entry, opcode three
// goes straight to the result, restart copies one entry per cycle, allocate
// examines one entry per cycle in the scan unit up to the block count (first
// fit stops at its hit). The next item is taken once the previous one is in
// the output register, so one finished result may wait on m_axis while the
// next is worked on. A stalled receiver holds the result; work then halts
// before delivery. Reset (synchronous, active low) clears the table, both
// config registers and all handshake state; the block is ready once reset is released.
module partition_fit_allocator_unit
    import pfa_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic                   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // block_index, amount, pad
    input  logic [OPCODE_W-1:0]    s_axis_tuser,  // opcode
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // chosen_block, left_over, pad
    output logic [STATUS_W-1:0]    m_axis_tuser   // status
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    pfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tuser  (s_axis_tuser),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    pfa_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser)
    );

endmodule

// File: sim/tb_top.sv
// Testbench for partition_fit_allocator_unit: items checked against a fit table predictor.
module tb_top;
    import pfa_pkg::*;

    localparam logic [STRAT_W-1:0] STRAT_FIRST = 2'd0;
    localparam logic [STRAT_W-1:0] STRAT_SPARE = 2'd3;  // unused code, behaves as first fit
    localparam int CYCLE_LIMIT = 300000;

    typedef struct packed {
        t_status               status;
        logic [CHOSEN_W-1:0]   chosen;
        logic [LEFT_W-1:0]     left_over;
    } t_fit_outcome;

    class t_fit_scoreboard;
        logic [AMOUNT_W-1:0] size_tbl [NUM_BLOCKS];
        logic [AMOUNT_W-1:0] remaining_tbl [NUM_BLOCKS];
        logic [STRAT_W-1:0]  strategy;
        logic [BCOUNT_W-1:0] block_count;
        t_fit_outcome        awaited_outcomes[$];
        int                  errors;

        function new();
            foreach (size_tbl[j]) begin
                size_tbl[j] = '0;
                remaining_tbl[j] = '0;
            end
            strategy = '0;
            block_count = '0;
            errors = 0;
        endfunction

        function void set_reg(logic idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_STRATEGY) begin
                strategy = val[STRAT_W-1:0];
            end else begin
                block_count = val[BCOUNT_W-1:0];
            end
        endfunction

        // Applies one item to the table and queues the outcome it must give.
        function void note_item(t_opcode op, logic [INDEX_W-1:0] idx,
                                logic [AMOUNT_W-1:0] amt);
            t_fit_outcome res;
            int           used;
            bit           found;
            int           pick;
            logic [AMOUNT_W-1:0] best_left;
            logic [AMOUNT_W-1:0] left;
            res = '{ST_NO_FIT, '0, '0};
            case (op)
                OP_LOAD: begin
                    size_tbl[idx] = amt;
                    remaining_tbl[idx] = amt;
                    res.status = ST_LOADED;
                end
                OP_RESTART: begin
                    foreach (size_tbl[j]) remaining_tbl[j] = size_tbl[j];
                    res.status = ST_RESTARTED;
                end
                OP_ALLOC: begin
                    used = (block_count > NUM_BLOCKS) ? NUM_BLOCKS : block_count;
                    found = 1'b0;
                    pick = 0;
                    best_left = '0;
                    for (int j = 0; j < used; j++) begin
                        if (remaining_tbl[j] != 0 && remaining_tbl[j] >= amt) begin
                            left = remaining_tbl[j] - amt;
                            if (!found) begin
                                found = 1'b1;
                                pick = j;
                                best_left = left;
                                if (strategy != STRAT_BEST && strategy != STRAT_WORST) break;
                            end else if (strategy == STRAT_BEST && left < best_left) begin
                                pick = j;
                                best_left = left;
                            end else if (strategy == STRAT_WORST && left > best_left) begin
                                pick = j;
                                best_left = left;
                            end
                        end
                    end
                    if (found) begin
                        remaining_tbl[pick] = best_left;
                        res = '{ST_ALLOCATED, pick[CHOSEN_W-1:0], best_left};
                    end
                end
                default: ;
            endcase
            awaited_outcomes.push_back(res);
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            errors++;
        endtask

        task check_result(logic [STATUS_W-1:0] st, logic [CHOSEN_W-1:0] chosen,
                          logic [LEFT_W-1:0] left_over);
            t_fit_outcome exp;
            if (awaited_outcomes.size() == 0) begin
                report($sformatf("unexpected result status=%0d block=%0d left=%0d",
                                 st, chosen, left_over));
            end else begin
                exp = awaited_outcomes.pop_front();
                if (st !== exp.status)
                    report($sformatf("status %0d, expected %0d", st, exp.status));
                if (chosen !== exp.chosen)
                    report($sformatf("chosen_block %0d, expected %0d", chosen, exp.chosen));
                if (left_over !== exp.left_over)
                    report($sformatf("left_over %0d, expected %0d", left_over, exp.left_over));
            end
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic                   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // block_index, amount, pad
    logic [OPCODE_W-1:0]    s_axis_tuser;   // opcode
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // chosen_block, left_over, pad
    logic [STATUS_W-1:0]    m_axis_tuser;   // status

    t_fit_scoreboard sb = new();
    bit              idle_on = 1'b1;
    int              cycles = 0;

    partition_fit_allocator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= !(idle_on && $urandom_range(0, 99) < 14);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tuser, m_axis_tdata[CHOSEN_W-1:0],
                            m_axis_tdata[CHOSEN_W +: LEFT_W]);
        end
    end

    task automatic send_item(t_opcode op, logic [INDEX_W-1:0] idx,
                             logic [AMOUNT_W-1:0] amt);
        @(negedge i_clk);
        while (idle_on && $urandom_range(0, 99) < 14) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(IN_TDATA_W - INDEX_W - AMOUNT_W){1'b0}}, amt, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(op, idx, amt);
    endtask

    // Stop sending and let every pending item come back.
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.awaited_outcomes.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    initial begin
        int counts [10];
        int r;
        t_opcode op;
        logic [AMOUNT_W-1:0] amt;

        counts = '{16, 1, 31, 0, 5, 16, 17, 12, 3, 16};
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_LOAD;
        m_axis_tready = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, odd opcode, extremes, ties, each strategy
        send_item(OP_ALLOC, 4'd0, 16'd5);
        send_item(OP_NONE, 4'hF, 16'hFFFF);
        settle();
        write_reg(CFG_BLOCK_COUNT, 5'd16);
        send_item(OP_LOAD, 4'd0, 16'd0);
        send_item(OP_LOAD, 4'd1, 16'd100);
        send_item(OP_LOAD, 4'd2, 16'd50);
        send_item(OP_LOAD, 4'd3, 16'hFFFF);
        send_item(OP_LOAD, 4'd7, 16'd50);
        send_item(OP_LOAD, 4'd15, 16'd200);
        send_item(OP_ALLOC, 4'd0, 16'd0);
        send_item(OP_ALLOC, 4'd0, 16'hFFFF);
        send_item(OP_ALLOC, 4'd0, 16'd1);
        send_item(OP_RESTART, 4'd0, 16'd0);
        settle();
        write_reg(CFG_STRATEGY, CFG_DATA_W'(STRAT_BEST));
        send_item(OP_ALLOC, 4'd0, 16'd50);
        send_item(OP_ALLOC, 4'd0, 16'd50);
        send_item(OP_ALLOC, 4'd0, 16'd60);
        settle();
        write_reg(CFG_STRATEGY, CFG_DATA_W'(STRAT_WORST));
        send_item(OP_ALLOC, 4'd0, 16'd10);
        send_item(OP_ALLOC, 4'd0, 16'd0);
        settle();
        write_reg(CFG_STRATEGY, CFG_DATA_W'(STRAT_SPARE));
        write_reg(CFG_BLOCK_COUNT, 5'd31);
        send_item(OP_ALLOC, 4'd0, 16'd10);
        send_item(OP_ALLOC, 4'd0, 16'd150);
        send_item(OP_ALLOC, 4'd0, 16'hFFFF);
        send_item(OP_RESTART, 4'd0, 16'd0);
        settle();
        write_reg(CFG_STRATEGY, CFG_DATA_W'(STRAT_FIRST));

        for (int p = 0; p < 10; p++) begin
            settle();
            idle_on = !(p == 4 || p == 5);
            write_reg(CFG_STRATEGY, CFG_DATA_W'(p[STRAT_W-1:0]));
            write_reg(CFG_BLOCK_COUNT, counts[p][CFG_DATA_W-1:0]);
            if ($urandom_range(0, 1)) begin
                for (int k = 0; k < NUM_BLOCKS; k++) begin
                    send_item(OP_LOAD, k[INDEX_W-1:0], AMOUNT_W'($urandom_range(1, 400)));
                end
            end
            for (int n = 0; n < 90; n++) begin
                r = $urandom_range(0, 99);
                op = (r < 25) ? OP_LOAD : (r < 33) ? OP_RESTART :
                     (r < 93) ? OP_ALLOC : OP_NONE;
                r = $urandom_range(0, 99);
                if (op == OP_LOAD) begin
                    amt = AMOUNT_W'((r < 30) ? $urandom() : (r < 80) ? $urandom_range(0, 255) :
                          ($urandom_range(0, 1) ? 32'hFFFF : 32'h0000));
                end else begin
                    amt = AMOUNT_W'((r < 40) ? $urandom_range(0, 63) :
                          (r < 70) ? $urandom_range(0, 255) : (r < 90) ? $urandom() :
                          ($urandom_range(0, 1) ? 32'hFFFF : 32'h0000));
                end
                send_item(op, INDEX_W'($urandom_range(0, NUM_BLOCKS - 1)), amt);
            end
        end

        settle();
        repeat (40) @(posedge i_clk);
        if (sb.awaited_outcomes.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.awaited_outcomes.size()));
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/pfa_pkg.sv
hdl/pfa_ctrl.sv
hdl/pfa_datapath.sv
hdl/partition_fit_allocator_unit.sv
sim/tb_top.sv
